// ===== hdl/sent_packet_ack_tracker_core_macros.svh =====
// Assertion macros for the tracker's checker.
`ifndef SENT_PACKET_ACK_TRACKER_CORE_MACROS_SVH
`define SENT_PACKET_ACK_TRACKER_CORE_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define SPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define SPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/spt_pkg.sv =====
// Types and constants of the sent packet ack tracker.
package spt_pkg;

  localparam int SEQ_W        = 16;
  localparam int ACK_BITS_W   = 32;
  localparam int LOSS_AGE_W   = 6;
  localparam int MODE_W       = 2;
  localparam int KIND_W       = 2;

  localparam logic [SEQ_W-1:0]      CNT_RESET      = 16'd33;
  localparam logic [LOSS_AGE_W-1:0] LOSS_AGE_RESET = 6'd32;

  typedef enum logic [MODE_W-1:0] {
    MODE_SEND  = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEQ   = 2'd0,
    KIND_ACKED = 2'd1,
    KIND_LOST  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEND,
    ST_ACK_MOD,
    ST_ACK_RD,
    ST_ACK_EV,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             valid;
    logic             acked;
    logic [SEQ_W-1:0] seq;
  } entry_t;

endpackage

// ===== hdl/spt_table_ram.sv =====
// Packet table memory: one write port, one registered read port.
module spt_table_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  spt_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output spt_pkg::entry_t rdata_o
);

  spt_pkg::entry_t mem [DEPTH];
  spt_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/spt_seq_ctrl.sv =====
// Sequencer: reset clear pass, send, ack walk, loss scan and result register.
module spt_seq_ctrl #(
  parameter int TABLE_DEPTH = 64,
  parameter int ACK_WINDOW  = 32,
  parameter int AW          = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [spt_pkg::LOSS_AGE_W-1:0]     loss_age_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [spt_pkg::MODE_W-1:0]         mode_i,
  input  logic [spt_pkg::SEQ_W-1:0]          ack_seq_i,
  input  logic [spt_pkg::ACK_BITS_W-1:0]     ack_bits_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [spt_pkg::KIND_W-1:0]         kind_o,
  output logic [spt_pkg::SEQ_W-1:0]          seq_number_o,
  output logic                               last_o,
  output logic                               ram_we_o,
  output logic [AW-1:0]                      ram_waddr_o,
  output spt_pkg::entry_t                    ram_wdata_o,
  output logic                               ram_re_o,
  output logic [AW-1:0]                      ram_raddr_o,
  input  spt_pkg::entry_t                    ram_rdata_i
);

  localparam int SW = spt_pkg::SEQ_W;
  localparam int WW = $clog2(ACK_WINDOW);
  localparam int LW = $clog2(ACK_WINDOW + 1);
  localparam int MW = 1;
  localparam int RK = SW + AW;
  localparam int PW = 2 * SW + 1;

  localparam logic [AW-1:0] LAST_IDX     = AW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] SLOT_RESET   = AW'(int'(spt_pkg::CNT_RESET) % TABLE_DEPTH);
  localparam logic [AW-1:0] SLOT_SEQ_MAX = AW'(((1 << SW) - 1) % TABLE_DEPTH);
  localparam logic [SW:0]   RECIP        = (SW + 1)'(((1 << RK) + TABLE_DEPTH - 1) / TABLE_DEPTH);
  localparam logic [SW-1:0] DEPTH_SW     = SW'(TABLE_DEPTH);
  localparam logic [WW-1:0] LAST_BIT     = WW'(ACK_WINDOW - 1);
  localparam logic [LW-1:0] LOST_MAX     = LW'(ACK_WINDOW);
  localparam logic [MW-1:0] MOD_LAST     = MW'(1);

  spt_pkg::state_e state_q, state_d;

  logic [AW-1:0]         scan_idx_q;
  logic [SW-1:0]         next_q;
  logic [AW-1:0]         send_slot_q;
  logic [LW-1:0]         lost_q;
  logic [WW-1:0]         bit_idx_q;
  logic [MW-1:0]         mod_cnt_q;
  logic [SW-1:0]         quot_q;
  logic [SW-1:0]         target_q;
  logic [ACK_WINDOW-1:0] win_bits_q;
  logic [AW-1:0]         rem_q;

  logic                  out_valid_q;
  spt_pkg::kind_e        out_kind_q;
  logic [SW-1:0]         out_seq_q;
  logic                  out_last_q;

  logic                  accept;
  logic                  slot_free;
  logic [SW-1:0]         new_seq;
  logic [AW-1:0]         new_slot;
  logic [PW-1:0]         quot_prod;
  logic [SW-1:0]         quot_next;
  logic [SW-1:0]         rem_full;
  logic [AW-1:0]         rem_next;
  logic [AW-1:0]         prev_slot;
  logic                  ack_report;
  logic                  ack_go;
  logic                  ack_skip;
  logic [SW-1:0]         age;
  logic                  stale;
  logic                  chk_report;
  logic                  chk_drop;
  logic                  chk_go;
  logic                  last_bit;
  logic                  last_idx;

  logic                  emit;
  spt_pkg::kind_e        emit_kind;
  logic [SW-1:0]         emit_seq;
  logic                  emit_last;

  assign in_ready_o = (state_q == spt_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign new_seq  = next_q + 1'b1;
  assign new_slot = ((next_q == '1) || (send_slot_q == LAST_IDX)) ? '0 : send_slot_q + 1'b1;

  // Reduce ack_seq modulo the table depth: reciprocal quotient first, then remainder.
  assign quot_prod = PW'(target_q) * PW'(RECIP);
  assign quot_next = SW'(quot_prod >> RK);
  assign rem_full  = target_q - quot_q * DEPTH_SW;
  assign rem_next  = rem_full[AW-1:0];

  // Slot of target - 1; the sequence wrap breaks the plain decrement.
  assign prev_slot = (target_q == '0) ? SLOT_SEQ_MAX :
                     (rem_q == '0)    ? LAST_IDX     : rem_q - 1'b1;

  assign last_bit = (bit_idx_q == LAST_BIT);
  assign last_idx = (scan_idx_q == LAST_IDX);

  assign ack_report = ram_rdata_i.valid && (ram_rdata_i.seq == target_q) && !ram_rdata_i.acked;
  assign ack_go     = !ack_report || slot_free;
  assign ack_skip   = !win_bits_q[bit_idx_q];

  assign age        = next_q - ram_rdata_i.seq;
  assign stale      = ram_rdata_i.valid && (age > SW'(loss_age_i));
  assign chk_drop   = stale && ram_rdata_i.acked;
  assign chk_report = stale && !ram_rdata_i.acked && (lost_q < LOST_MAX);
  assign chk_go     = !chk_report || slot_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      spt_pkg::ST_CLEAR: begin
        if (last_idx) state_d = spt_pkg::ST_IDLE;
      end
      spt_pkg::ST_IDLE: begin
        if (accept) begin
          case (spt_pkg::mode_e'(mode_i))
            spt_pkg::MODE_SEND:  state_d = spt_pkg::ST_SEND;
            spt_pkg::MODE_ACK:   state_d = spt_pkg::ST_ACK_MOD;
            spt_pkg::MODE_CHECK: state_d = spt_pkg::ST_CHK_RD;
            default:             state_d = spt_pkg::ST_DONE;
          endcase
        end
      end
      spt_pkg::ST_SEND: begin
        if (slot_free) state_d = spt_pkg::ST_IDLE;
      end
      spt_pkg::ST_ACK_MOD: begin
        if (mod_cnt_q == MOD_LAST) state_d = spt_pkg::ST_ACK_RD;
      end
      spt_pkg::ST_ACK_RD: begin
        if (!ack_skip) begin
          state_d = spt_pkg::ST_ACK_EV;
        end else if (last_bit) begin
          state_d = spt_pkg::ST_DONE;
        end
      end
      spt_pkg::ST_ACK_EV: begin
        if (ack_go) state_d = last_bit ? spt_pkg::ST_DONE : spt_pkg::ST_ACK_RD;
      end
      spt_pkg::ST_CHK_RD: begin
        state_d = spt_pkg::ST_CHK_EV;
      end
      spt_pkg::ST_CHK_EV: begin
        if (chk_go) state_d = last_idx ? spt_pkg::ST_DONE : spt_pkg::ST_CHK_RD;
      end
      spt_pkg::ST_DONE: begin
        if (slot_free) state_d = spt_pkg::ST_IDLE;
      end
      default: state_d = spt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = scan_idx_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = scan_idx_q;
    emit        = 1'b0;
    emit_kind   = spt_pkg::KIND_DONE;
    emit_seq    = '0;
    emit_last   = 1'b0;
    case (state_q)
      spt_pkg::ST_CLEAR: begin
        ram_we_o = 1'b1;
      end
      spt_pkg::ST_SEND: begin
        if (slot_free) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = new_slot;
          ram_wdata_o = '{valid: 1'b1, acked: 1'b0, seq: new_seq};
          emit        = 1'b1;
          emit_kind   = spt_pkg::KIND_SEQ;
          emit_seq    = new_seq;
          emit_last   = 1'b1;
        end
      end
      spt_pkg::ST_ACK_RD: begin
        ram_re_o    = !ack_skip;
        ram_raddr_o = rem_q;
      end
      spt_pkg::ST_ACK_EV: begin
        if (ack_report && slot_free) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = rem_q;
          ram_wdata_o = '{valid: 1'b1, acked: 1'b1, seq: target_q};
          emit        = 1'b1;
          emit_kind   = spt_pkg::KIND_ACKED;
          emit_seq    = target_q;
        end
      end
      spt_pkg::ST_CHK_RD: begin
        ram_re_o = 1'b1;
      end
      spt_pkg::ST_CHK_EV: begin
        // Retire acked stale entries at once; unacked ones wait for the output, and stay once lost_q reaches its cap.
        if (chk_drop || (chk_report && slot_free)) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = '{valid: 1'b0, acked: ram_rdata_i.acked, seq: ram_rdata_i.seq};
        end
        if (chk_report && slot_free) begin
          emit      = 1'b1;
          emit_kind = spt_pkg::KIND_LOST;
          emit_seq  = ram_rdata_i.seq;
        end
      end
      spt_pkg::ST_DONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spt_pkg::ST_CLEAR;
      scan_idx_q  <= '0;
      next_q      <= spt_pkg::CNT_RESET;
      send_slot_q <= SLOT_RESET;
      lost_q      <= '0;
      bit_idx_q   <= '0;
      mod_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        scan_idx_q <= '0;
        lost_q     <= '0;
        bit_idx_q  <= '0;
        mod_cnt_q  <= '0;
      end
      if ((state_q == spt_pkg::ST_CLEAR) ||
          ((state_q == spt_pkg::ST_CHK_EV) && chk_go)) begin
        scan_idx_q <= last_idx ? '0 : scan_idx_q + 1'b1;
      end
      if ((state_q == spt_pkg::ST_SEND) && slot_free) begin
        next_q      <= new_seq;
        send_slot_q <= new_slot;
      end
      if ((state_q == spt_pkg::ST_CHK_EV) && chk_report && slot_free) begin
        lost_q <= lost_q + 1'b1;
      end
      if (state_q == spt_pkg::ST_ACK_MOD) begin
        mod_cnt_q <= mod_cnt_q + 1'b1;
      end
      if (((state_q == spt_pkg::ST_ACK_RD) && ack_skip) ||
          ((state_q == spt_pkg::ST_ACK_EV) && ack_go)) begin
        bit_idx_q <= bit_idx_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q   <= ack_seq_i;
      win_bits_q <= ack_bits_i[ACK_WINDOW-1:0];
      rem_q      <= '0;
    end
    // The remainder is valid after the second step, once the quotient has settled.
    if (state_q == spt_pkg::ST_ACK_MOD) begin
      quot_q <= quot_next;
      rem_q  <= rem_next;
    end
    // Advance to the next older sequence of the ack window.
    if (((state_q == spt_pkg::ST_ACK_RD) && ack_skip) ||
        ((state_q == spt_pkg::ST_ACK_EV) && ack_go)) begin
      target_q <= target_q - 1'b1;
      rem_q    <= prev_slot;
    end
    if (emit) begin
      out_kind_q <= emit_kind;
      out_seq_q  <= emit_seq;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign seq_number_o = out_seq_q;
  assign last_o       = out_last_q;

endmodule

// ===== hdl/sent_packet_ack_tracker_core.sv =====
// Sent packet ack tracker: top level with the loss age register.
//
// Input channel (in_valid_i/in_ready_o) takes one command per transaction:
// mode_i 0 sends a packet, 1 applies ack_seq_i/ack_bits_i, 2 checks for
// lost packets, 3 only returns a done result. Output channel
// (out_valid_o/out_ready_i) returns events: kind_o, seq_number_o and
// last_o, which marks the final result of a command. cfg_we_i/cfg_wdata_i
// write loss_age; the user must do so only while idle, as the block does
// not enforce it. Commands run one at a time; in_ready_o is high only
// while idle. Send: the new sequence number is written to the table and
// registered as the result once the result register is free. Ack:
// ack_seq_i is reduced modulo the table depth, then each window bit is
// taken in turn: a clear bit is skipped, a set bit reads the table and
// then marks a matching unacked entry acked; a done result follows.
// Check: each table entry is read, then checked. Reset: the table is
// cleared one entry a cycle, with in_ready_o low; the counter restarts
// at 33, loss_age at 32. A stalled receiver holds the result register
// and the sequencer waits in place; nothing is dropped.
module sent_packet_ack_tracker_core #(
  parameter int TABLE_DEPTH = 64,
  parameter int ACK_WINDOW  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [spt_pkg::LOSS_AGE_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [spt_pkg::MODE_W-1:0]         mode_i,
  input  logic [spt_pkg::SEQ_W-1:0]          ack_seq_i,
  input  logic [spt_pkg::ACK_BITS_W-1:0]     ack_bits_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [spt_pkg::KIND_W-1:0]         kind_o,
  output logic [spt_pkg::SEQ_W-1:0]          seq_number_o,
  output logic                               last_o
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [spt_pkg::LOSS_AGE_W-1:0] loss_age_q;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  spt_pkg::entry_t ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  spt_pkg::entry_t ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_age_q <= spt_pkg::LOSS_AGE_RESET;
    end else if (cfg_we_i) begin
      loss_age_q <= cfg_wdata_i;
    end
  end

  spt_seq_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ACK_WINDOW  (ACK_WINDOW),
    .AW          (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .loss_age_i   (loss_age_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .ack_seq_i    (ack_seq_i),
    .ack_bits_i   (ack_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .seq_number_o (seq_number_o),
    .last_o       (last_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  spt_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== hdl/spt_chk.sv =====
// Port-level checker for the tracker, bound to the top level.
`include "sent_packet_ack_tracker_core_macros.svh"

module spt_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [spt_pkg::KIND_W-1:0]     kind_o,
  input logic [spt_pkg::SEQ_W-1:0]      seq_number_o,
  input logic                           last_o
);

  // A command occupies the block: no second transaction right behind it.
  `SPT_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "input taken while a command is in progress")

  // Hold a stalled result.
  `SPT_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(kind_o) && $stable(seq_number_o) && $stable(last_o)), "stalled result changed")

  // More results follow a non-final one before the next command.
  `SPT_ASSERT(a_not_last_busy, clk_i, rst_ni, (out_valid_o && !last_o) |-> !in_ready_o, "command ended without a final result")

  `SPT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind sent_packet_ack_tracker_core spt_chk u_spt_chk (.*);
